### hdl/composite_video_line_encoder_core_assert.svh
// Assertion macros shared by the checker.
`ifndef COMPOSITE_VIDEO_LINE_ENCODER_CORE_ASSERT_SVH
`define COMPOSITE_VIDEO_LINE_ENCODER_CORE_ASSERT_SVH

// Implication checked on every clock outside reset.
`define CVE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every clock outside reset.
`define CVE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CVE_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/cve_pkg.sv
`timescale 1ns / 1ps
package cve_pkg;

  localparam int MaxTaps  = 13;
  localparam int CoefW    = 14;
  localparam int ProdW    = 31;
  localparam int HalfPal  = 6;
  localparam int HalfNtsc = 4;

  localparam logic [15:0] LEVEL_LOW   = 16'h0100;
  localparam logic [15:0] LEVEL_HIGH  = 16'hFEFF;
  localparam logic [15:0] LUMA_OFFSET = 16'd4096;
  localparam logic [15:0] ROUND_Q15   = 16'd16384;
  localparam logic [3:0]  FILL_MAX    = 4'd15;

  // register indexes
  localparam logic [2:0] REG_STD    = 3'd0;
  localparam logic [2:0] REG_BLACK  = 3'd1;
  localparam logic [2:0] REG_NUM    = 3'd2;
  localparam logic [2:0] REG_DEN    = 3'd3;
  localparam logic [2:0] REG_UGAIN  = 3'd4;
  localparam logic [2:0] REG_VGAIN  = 3'd5;

  localparam logic [CoefW-1:0] PAL_TAPS [13] = '{
    14'd4, 14'd38, 14'd270, 14'd1226, 14'd3619, 14'd6927, 14'd8600,
    14'd6927, 14'd3619, 14'd1226, 14'd270, 14'd38, 14'd4};
  localparam logic [CoefW-1:0] NTSC_TAPS [9] = '{
    14'd69, 14'd626, 14'd2959, 14'd7563, 14'd10334, 14'd7563, 14'd2959,
    14'd626, 14'd69};

  typedef enum logic [1:0] {
    ST_IDLE, ST_SEL, ST_CALC, ST_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_MUL, CS_SUM, CS_UF, CS_DIV, CS_CHR, CS_FIN
  } comp_state_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic [15:0]        black;
    logic [8:0]         num;
    logic [8:0]         den;
    logic [15:0]        ugain;
    logic [15:0]        vgain;
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
    logic               vsw;
    logic [1:0]         phase;
    logic [15:0]        luma;
  } comp_args_t;

  // filter weight of window position idx (symmetric taps)
  function automatic logic [CoefW-1:0] tap_coef(input int idx, input logic ntsc);
    logic [CoefW-1:0] c;
    c = '0;
    if (ntsc) begin
      if (idx < 9) c = NTSC_TAPS[idx];
    end else begin
      if (idx < 13) c = PAL_TAPS[idx];
    end
    return c;
  endfunction

endpackage

### hdl/composite_video_line_encoder_core.sv
`timescale 1ns / 1ps
// Composite line encoder, 4x subcarrier samples for active picture.
// Input stream: one pixel per request; tdata carries Y, Cb, Cr and the
// line-start carrier sine/cosine, tuser the line-first and V-switch flags,
// tlast marks the last pixel of the line.
// Output stream: one composite sample per request, tlast on the last sample
// of a line. Samples lag the pixels by half the filter (6 PAL, 4 NTSC);
// the lagging samples are flushed after the last pixel of the line.
// Each sample is computed by a sequencer over the tap cells, mostly in the
// 27-step luma divider. The input reopens once the pixel's sample, if any,
// and any flushed samples have entered the output register.
// One item is in flight at a time; s_tready is high only when idle.
// An output register holds a finished sample while the receiver stalls;
// the next sample waits in the sequencer until the register frees.
// Reset (synchronous) restores the register defaults, clears the filter
// windows, carrier latch, phase and fill count; no clearing pass is needed.
// Configuration writes are taken any cycle and belong in idle time.
module composite_video_line_encoder_core import cve_pkg::*; #(
  parameter int MAX_TAPS = MaxTaps
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // luma_in, cb_in, cr_in, carrier_sine, carrier_cosine
  input  logic [1:0]  s_tuser,   // line_first, vswitch_negative
  input  logic        s_tlast,   // line_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // composite_sample
  output logic        m_tlast,   // line_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LumaDepth = (MAX_TAPS + 1) / 2;
  localparam int LumaIw    = $clog2(LumaDepth);

  top_state_t state, state_next;

  logic        std_sel;
  logic [15:0] black, ugain, vgain;
  logic [8:0]  num, den;

  logic signed [15:0] line_sine, line_cosine;
  logic               line_vsw;
  logic [1:0]         phase;
  logic [3:0]         fill, fill_base, fill_new;
  logic [2:0]         flush_left, half;
  logic               need_out, line_done;
  logic [15:0]        luma_delay [LumaDepth];
  logic [15:0]        luma_tap;

  logic               accept, push_zero, end_line, comp_start, comp_done, load_out;
  cell_ctl_t          ctl;
  logic signed [15:0] cb_new, cr_new;
  logic signed [15:0] cb_w [MAX_TAPS];
  logic signed [15:0] cr_w [MAX_TAPS];
  logic signed [ProdW-1:0] prod_u [MAX_TAPS];
  logic signed [ProdW-1:0] prod_v [MAX_TAPS];
  comp_args_t         args;
  logic [15:0]        comp_result;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign half      = std_sel ? 3'(HalfNtsc) : 3'(HalfPal);
  assign fill_base = s_tuser[0] ? 4'd0 : fill;
  assign fill_new  = (fill_base == FILL_MAX) ? FILL_MAX : fill_base + 4'd1;
  assign load_out  = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      std_sel <= 1'b0;
      black   <= 16'd16384;
      num     <= 9'd147;
      den     <= 9'd219;
      ugain   <= 16'd18752;
      vgain   <= 16'd26449;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STD:   std_sel <= cfg_data[0];
        REG_BLACK: black   <= cfg_data;
        REG_NUM:   num     <= cfg_data[8:0];
        REG_DEN:   den     <= cfg_data[8:0];
        REG_UGAIN: ugain   <= cfg_data;
        REG_VGAIN: vgain   <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    push_zero  = 1'b0;
    end_line   = 1'b0;
    comp_start = 1'b0;
    case (state)
      ST_IDLE: if (accept) state_next = ST_SEL;
      ST_SEL: begin
        if (need_out) begin
          comp_start = 1'b1;
          state_next = ST_CALC;
        end else if (flush_left != '0) begin
          push_zero = 1'b1;
        end else begin
          end_line   = line_done;
          state_next = ST_IDLE;
        end
      end
      ST_CALC: if (comp_done) state_next = ST_EMIT;
      ST_EMIT: if (load_out) state_next = ST_SEL;
      default: state_next = ST_IDLE;
    endcase
  end

  // window control: new pixel, flush zeros, or line-end clear
  always_comb begin
    ctl.shift = accept || push_zero;
    ctl.clear = (accept && s_tuser[0]) || end_line;
    cb_new    = accept ? $signed({~s_tdata[31], s_tdata[30:16]}) : '0;
    cr_new    = accept ? $signed({~s_tdata[47], s_tdata[46:32]}) : '0;
  end

  // line bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      line_sine   <= '0;
      line_cosine <= '0;
      line_vsw    <= 1'b0;
      phase       <= '0;
      fill        <= '0;
      flush_left  <= '0;
      need_out    <= 1'b0;
      line_done   <= 1'b0;
    end else begin
      if (accept) begin
        if (s_tuser[0]) begin
          line_sine   <= $signed(s_tdata[63:48]);
          line_cosine <= $signed(s_tdata[79:64]);
          line_vsw    <= s_tuser[1];
        end
        fill       <= fill_new;
        need_out   <= (fill_new > {1'b0, half});
        line_done  <= s_tlast;
        flush_left <= !s_tlast ? 3'd0 :
                      (fill_new < {1'b0, half}) ? fill_new[2:0] : half;
      end
      if (comp_start) need_out <= 1'b0;
      if (push_zero) begin
        flush_left <= flush_left - 3'd1;
        need_out   <= 1'b1;
      end
      if ((accept && s_tuser[0]) || end_line) phase <= '0;
      else if (load_out)                      phase <= phase + 2'd1;
      if (end_line) fill <= '0;
    end
  end

  // luma delay line, matched to the filter center
  always_ff @(posedge clk) begin
    for (int i = 0; i < LumaDepth; i++) begin
      if (rst) begin
        luma_delay[i] <= '0;
      end else if (ctl.shift) begin
        if (i == 0)         luma_delay[i] <= accept ? s_tdata[15:0] : 16'd0;
        else if (ctl.clear) luma_delay[i] <= '0;
        else                luma_delay[i] <= luma_delay[(i == 0) ? 0 : i - 1];
      end else if (ctl.clear) begin
        luma_delay[i] <= '0;
      end
    end
  end

  assign luma_tap = ({1'b0, half} < 4'(LumaDepth)) ? luma_delay[half[LumaIw-1:0]] : 16'd0;

  // chain of tap cells
  for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
    cve_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .ntsc    (std_sel),
      .cb_prev ((g == 0) ? cb_new : cb_w[(g == 0) ? 0 : g - 1]),
      .cr_prev ((g == 0) ? cr_new : cr_w[(g == 0) ? 0 : g - 1]),
      .cb_q    (cb_w[g]),
      .cr_q    (cr_w[g]),
      .prod_u  (prod_u[g]),
      .prod_v  (prod_v[g])
    );
  end

  always_comb begin
    args.black  = black;
    args.num    = num;
    args.den    = den;
    args.ugain  = ugain;
    args.vgain  = vgain;
    args.sine   = line_sine;
    args.cosine = line_cosine;
    args.vsw    = line_vsw;
    args.phase  = phase;
    args.luma   = luma_tap;
  end

  cve_comp #(.MAX_TAPS(MAX_TAPS)) u_comp (
    .clk    (clk),
    .rst    (rst),
    .start  (comp_start),
    .args   (args),
    .prod_u (prod_u),
    .prod_v (prod_v),
    .done   (comp_done),
    .result (comp_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= comp_result;
      m_tlast <= line_done && (flush_left == '0);
    end
  end

endmodule

### hdl/cve_cell.sv
`timescale 1ns / 1ps
module cve_cell import cve_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctl_t               ctl,
  input  logic                    ntsc,
  input  logic signed [15:0]      cb_prev,
  input  logic signed [15:0]      cr_prev,
  output logic signed [15:0]      cb_q,
  output logic signed [15:0]      cr_q,
  output logic signed [ProdW-1:0] prod_u,
  output logic signed [ProdW-1:0] prod_v
);

  logic signed [CoefW:0] coef;

  assign coef = $signed({1'b0, tap_coef(IDX, ntsc)});

  // window sample: shift from neighbor, clear at line boundaries
  always_ff @(posedge clk) begin
    if (rst) begin
      cb_q <= '0;
      cr_q <= '0;
    end else if (ctl.shift) begin
      if (ctl.clear && IDX != 0) begin
        cb_q <= '0;
        cr_q <= '0;
      end else begin
        cb_q <= cb_prev;
        cr_q <= cr_prev;
      end
    end else if (ctl.clear) begin
      cb_q <= '0;
      cr_q <= '0;
    end
  end

  // weighted sample, refreshed every cycle
  always_ff @(posedge clk) begin
    prod_u <= cb_q * coef;
    prod_v <= cr_q * coef;
  end

endmodule

### hdl/cve_comp.sv
`timescale 1ns / 1ps
module cve_comp import cve_pkg::*; #(
  parameter int MAX_TAPS = MaxTaps
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  comp_args_t              args,
  input  logic signed [ProdW-1:0] prod_u [MAX_TAPS],
  input  logic signed [ProdW-1:0] prod_v [MAX_TAPS],
  output logic                    done,
  output logic [15:0]             result
);

  localparam int SumW  = 34;
  localparam int Split = (MAX_TAPS + 1) / 2;

  comp_state_t state, state_next;

  logic signed [SumW-1:0] su_lo, su_hi, sv_lo, sv_hi;
  logic signed [SumW-1:0] hu_lo, hu_hi, hv_lo, hv_hi, au, av;
  logic signed [16:0]     uf, vf, yl;
  logic signed [26:0]     lnum, lmag;
  logic signed [17:0]     cu, cv;
  logic signed [34:0]     cu_full, cv_full;
  logic [26:0]            dvd;
  logic [8:0]             rem, den_eff;
  logic [9:0]             rem_sh;
  logic                   neg;
  logic [4:0]             cnt;
  logic signed [16:0]     s_sel, c_sel, sn, cs;
  logic signed [35:0]     pu, pv, csum;
  logic signed [27:0]     q;
  logic signed [29:0]     tot;

  // split adder tree over the cell products
  always_comb begin
    su_lo = '0;
    su_hi = '0;
    sv_lo = '0;
    sv_hi = '0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      if (i < Split) begin
        su_lo = su_lo + SumW'(prod_u[i]);
        sv_lo = sv_lo + SumW'(prod_v[i]);
      end else begin
        su_hi = su_hi + SumW'(prod_u[i]);
        sv_hi = sv_hi + SumW'(prod_v[i]);
      end
    end
  end

  assign au      = hu_lo + hu_hi;
  assign av      = hv_lo + hv_hi;
  assign yl      = $signed({1'b0, args.luma}) - $signed({1'b0, LUMA_OFFSET});
  assign den_eff = (args.den == '0) ? 9'd1 : args.den;
  assign lmag    = lnum[26] ? -lnum : lnum;
  assign rem_sh  = {rem, dvd[26]};
  assign cu_full = (35'(uf) * $signed({1'b0, args.ugain})) + 35'(ROUND_Q15);
  assign cv_full = (35'(vf) * $signed({1'b0, args.vgain})) + 35'(ROUND_Q15);
  assign sn      = 17'(args.sine);
  assign cs      = 17'(args.cosine);
  assign csum    = pu + pv + 36'(ROUND_Q15);
  assign tot     = $signed({14'd0, args.black}) + 30'(q) + 30'(csum >>> 15);

  // carrier rotation through the four sample phases
  always_comb begin
    case (args.phase)
      2'd0: begin
        s_sel = sn;
        c_sel = args.vsw ? -cs : cs;
      end
      2'd1: begin
        s_sel = cs;
        c_sel = args.vsw ? sn : -sn;
      end
      2'd2: begin
        s_sel = -sn;
        c_sel = args.vsw ? cs : -cs;
      end
      default: begin
        s_sel = -cs;
        c_sel = args.vsw ? -sn : sn;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= CS_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: if (start) state_next = CS_MUL;
      CS_MUL:  state_next = CS_SUM;
      CS_SUM:  state_next = CS_UF;
      CS_UF:   state_next = CS_DIV;
      CS_DIV:  if (cnt == 5'd26) state_next = CS_CHR;
      CS_CHR:  state_next = CS_FIN;
      CS_FIN:  state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (state == CS_FIN);
  end

  // datapath steps
  always_ff @(posedge clk) begin
    case (state)
      CS_MUL: begin
        hu_lo <= su_lo;
        hu_hi <= su_hi;
        hv_lo <= sv_lo;
        hv_hi <= sv_hi;
      end
      CS_SUM: begin
        uf   <= 17'((au + SumW'(ROUND_Q15)) >>> 15);
        vf   <= 17'((av + SumW'(ROUND_Q15)) >>> 15);
        lnum <= yl * $signed({1'b0, args.num});
      end
      CS_UF: begin
        cu  <= 18'(cu_full >>> 15);
        cv  <= 18'(cv_full >>> 15);
        neg <= lnum[26];
        dvd <= 27'(lmag) + 27'(den_eff[8:1]);
        rem <= '0;
        cnt <= '0;
      end
      CS_DIV: begin
        // one quotient bit per cycle, restoring
        if (rem_sh >= {1'b0, den_eff}) begin
          rem <= 9'(rem_sh - {1'b0, den_eff});
          dvd <= {dvd[25:0], 1'b1};
        end else begin
          rem <= rem_sh[8:0];
          dvd <= {dvd[25:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      CS_CHR: begin
        pu <= 36'(cu * s_sel);
        pv <= 36'(cv * c_sel);
        q  <= neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
      end
      CS_FIN: begin
        if (tot < $signed({14'd0, LEVEL_LOW}))       result <= LEVEL_LOW;
        else if (tot > $signed({14'd0, LEVEL_HIGH})) result <= LEVEL_HIGH;
        else                                         result <= tot[15:0];
      end
      default: ;
    endcase
  end

endmodule

### hdl/cve_checker.sv
`timescale 1ns / 1ps
`include "composite_video_line_encoder_core_assert.svh"
module cve_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // nothing left over after reset
  `CVE_ASSERT_RST(a_rst_empty, rst, !m_tvalid, "output valid after reset")

  // one pixel at a time: a request closes the input until its work is done
  `CVE_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "input reopened at once")

  // samples always inside the legal level range
  `CVE_ASSERT_IMP(a_clamp, m_tvalid, (m_tdata >= 16'h0100) && (m_tdata <= 16'hFEFF), "level out of range")

  // stalled output holds
  `CVE_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output changed")

endmodule

bind composite_video_line_encoder_core cve_checker u_cve_checker (.*);

### tb/sv/composite_video_line_encoder_core_test.sv
`timescale 1ns / 1ps
module composite_video_line_encoder_core_test;
  import cve_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 80;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [15:0]        y;
    logic [15:0]        cb;
    logic [15:0]        cr;
    logic               first;
    logic               last;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
    logic               vsw;
  } pixel_t;

  typedef struct {
    logic [15:0] level;
    logic        line_end;
  } sample_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  composite_video_line_encoder_core u_top (.*);

  pixel_t  pixel_fifo[$];
  sample_t sample_fifo[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      pixels_sent = 0;
  int      samples_seen = 0;
  int      snd_idle = 0;
  int      rcv_idle = 0;
  logic    in_acc = 0;
  logic    hold_go = 0;
  logic    hold_done = 0;
  int      hold_cnt = 0;

  // encoder model state
  logic    m_ntsc;
  longint  m_black, m_num, m_den, m_ugain, m_vgain;
  longint  cb_win[MaxTaps], cr_win[MaxTaps], y_dly[7];
  longint  l_sine, l_cosine;
  logic    l_vsw;
  int      phase, fill;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  function automatic void clear_lines();
    foreach (cb_win[i]) begin
      cb_win[i] = 0;
      cr_win[i] = 0;
    end
    foreach (y_dly[i]) y_dly[i] = 0;
  endfunction

  function automatic void shift_in(input longint cb, input longint cr, input longint y);
    for (int i = MaxTaps - 1; i > 0; i--) begin
      cb_win[i] = cb_win[i-1];
      cr_win[i] = cr_win[i-1];
    end
    for (int i = 6; i > 0; i--) y_dly[i] = y_dly[i-1];
    cb_win[0] = cb;
    cr_win[0] = cr;
    y_dly[0] = y;
  endfunction

  // composite level of the pixel at the filter center
  function automatic logic [15:0] composite_level();
    int     n;
    longint au, av, uf, vf, coef, q, num, dv, cu, cv, sgn_s, sgn_c, chroma, lvl;
    n = m_ntsc ? 9 : 13;
    au = 0;
    av = 0;
    for (int j = 0; j < n; j++) begin
      coef = m_ntsc ? longint'(NTSC_TAPS[j]) : longint'(PAL_TAPS[j]);
      au += coef * cb_win[n-1-j];
      av += coef * cr_win[n-1-j];
    end
    uf = (au + 16384) >>> 15;
    vf = (av + 16384) >>> 15;
    dv = (m_den == 0) ? 1 : m_den;
    num = (y_dly[n/2] - 4096) * m_num;
    q = (num >= 0 ? num + dv / 2 : num - dv / 2) / dv;
    cu = (uf * m_ugain + 16384) >>> 15;
    cv = (vf * m_vgain + 16384) >>> 15;
    case (phase)
      0: begin sgn_s = l_sine;    sgn_c = l_vsw ? -l_cosine : l_cosine; end
      1: begin sgn_s = l_cosine;  sgn_c = l_vsw ? l_sine : -l_sine; end
      2: begin sgn_s = -l_sine;   sgn_c = l_vsw ? l_cosine : -l_cosine; end
      default: begin sgn_s = -l_cosine; sgn_c = l_vsw ? -l_sine : l_sine; end
    endcase
    chroma = (cu * sgn_s + cv * sgn_c + 16384) >>> 15;
    phase = (phase + 1) % 4;
    lvl = m_black + q + chroma;
    if (lvl < longint'(LEVEL_LOW)) lvl = LEVEL_LOW;
    if (lvl > longint'(LEVEL_HIGH)) lvl = LEVEL_HIGH;
    return lvl[15:0];
  endfunction

  // expected samples for one accepted pixel
  function automatic void encode_pixel(input pixel_t p);
    int      h, pend, made;
    sample_t s;
    h = m_ntsc ? 4 : 6;
    made = 0;
    if (p.first) begin
      clear_lines();
      l_sine = p.sn;
      l_cosine = p.cs;
      l_vsw = p.vsw;
      phase = 0;
      fill = 0;
    end
    shift_in(longint'(p.cb) - 32768, longint'(p.cr) - 32768, longint'(p.y));
    if (fill < 15) fill++;
    if (fill > h) begin
      s.level = composite_level();
      s.line_end = 0;
      sample_fifo.push_back(s);
      made++;
    end
    if (p.last) begin
      pend = (fill < h) ? fill : h;
      for (int i = 0; i < pend; i++) begin
        shift_in(0, 0, 0);
        s.level = composite_level();
        s.line_end = 0;
        sample_fifo.push_back(s);
        made++;
      end
      if (made > 0) sample_fifo[$].line_end = 1;
      clear_lines();
      phase = 0;
      fill = 0;
    end
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_STD:   m_ntsc = val[0];
      REG_BLACK: m_black = val;
      REG_NUM:   m_num = val[8:0];
      REG_DEN:   m_den = val[8:0];
      REG_UGAIN: m_ugain = val;
      REG_VGAIN: m_vgain = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic add_pixel(input logic [15:0] y, input logic [15:0] cb, input logic [15:0] cr,
                           input logic first, input logic last, input logic [15:0] sn,
                           input logic [15:0] cs, input logic vsw);
    pixel_t p;
    p = '{y, cb, cr, first, last, sn, cs, vsw};
    pixel_fifo.push_back(p);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly well-formed lines, some with missing or misplaced marks
  task automatic add_lines(input int count);
    int n, len, kind, cut;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 28) : $urandom_range(1, 12);
      kind = $urandom_range(0, 9);
      cut = $urandom_range(1, len);
      for (int i = 0; i < len; i++) begin
        add_pixel(rand_word(), rand_word(), rand_word(),
                  (i == 0 && kind != 0) || (kind == 1 && i == cut),
                  (i == len - 1) && kind != 2,
                  rand_word(), rand_word(), 1'($urandom_range(0, 1)));
      end
      n += len;
    end
  endtask

  task automatic drain();
    wait (pixel_fifo.size() == 0 && !s_tvalid && sample_fifo.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // pixel driver
  always @(negedge clk) begin
    pixel_t p;
    if (!s_tvalid || in_acc) begin
      if (!rst && pixel_fifo.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
        p = pixel_fifo.pop_front();
        s_tvalid <= 1;
        s_tdata <= {p.cs, p.sn, p.cr, p.cb, p.y};
        s_tuser <= {p.vsw, p.first};
        s_tlast <= p.last;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // sample receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      m_tready <= 0;
      hold_cnt = hold_cnt - 1;
    end else if (hold_go && !hold_done) begin
      hold_done = 1;
      hold_cnt = HOLD_CYCLES;
      m_tready <= 0;
    end else begin
      m_tready <= !rst && ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // predict on accepted pixels, check accepted samples
  always @(posedge clk) begin
    pixel_t  p;
    sample_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end else if (!rst) begin
      in_acc <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        p = '{s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tuser[0], s_tlast,
              s_tdata[63:48], s_tdata[79:64], s_tuser[1]};
        encode_pixel(p);
        pixels_sent++;
      end
      if (m_tvalid && m_tready) begin
        samples_seen++;
        if (sample_fifo.size() == 0) begin
          report("unexpected sample", m_tdata, -1);
        end else begin
          want = sample_fifo.pop_front();
          if (m_tdata !== want.level) report("composite_sample", m_tdata, want.level);
          if (m_tlast !== want.line_end) report("line_end", m_tlast, want.line_end);
        end
      end
    end
  end

  initial begin
    m_ntsc = 0;
    m_black = 16384;
    m_num = 147;
    m_den = 219;
    m_ugain = 18752;
    m_vgain = 26449;
    clear_lines();
    l_sine = 0;
    l_cosine = 0;
    l_vsw = 0;
    phase = 0;
    fill = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: reset settings, sender light idle, receiver heavy idle
    snd_idle = 23;
    rcv_idle = 82;
    // one-pixel line at the field extremes
    add_pixel(16'h0000, 16'h0000, 16'h0000, 1, 1, 16'h8000, 16'h7FFF, 1);
    add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 16'h7FFF, 16'h8000, 0);
    // full PAL line, alternating extremes
    for (int i = 0; i < 8; i++)
      add_pixel(i[0] ? 16'hFFFF : 16'h1000, i[0] ? 16'h0000 : 16'hFFFF,
                i[1] ? 16'hFFFF : 16'h0000, i == 0, i == 7, 16'h5A82, 16'hA57E, 0);
    // line without a first mark reuses the held carrier
    for (int i = 0; i < 3; i++)
      add_pixel(16'h8000, 16'hC000, 16'h4000, 0, i == 2, 16'h0000, 16'h0000, 0);
    // restart in the middle of a line drops pending samples
    for (int i = 0; i < 8; i++)
      add_pixel(16'hEB00, 16'h2000, 16'hE000, i == 0 || i == 3, i == 7,
                16'h3000, 16'hD000, i > 2);
    add_lines(20);
    drain();

    // NTSC, extreme gains
    write_reg(REG_STD, 16'd1);
    write_reg(REG_BLACK, 16'd0);
    write_reg(REG_NUM, 16'd511);
    write_reg(REG_DEN, 16'd1);
    write_reg(REG_UGAIN, 16'hFFFF);
    write_reg(REG_VGAIN, 16'd0);
    add_lines(120);
    drain();

    // PAL, zero divisor, roles of the sides swapped
    snd_idle = 82;
    rcv_idle = 23;
    write_reg(REG_STD, 16'd0);
    write_reg(REG_BLACK, 16'hFFFF);
    write_reg(REG_NUM, 16'd0);
    write_reg(REG_DEN, 16'd0);
    write_reg(REG_UGAIN, 16'd0);
    write_reg(REG_VGAIN, 16'hFFFF);
    add_lines(120);
    drain();

    // NTSC with nominal black level and numerator, divisor 511, random chroma gains, no idling, long stall
    snd_idle = 0;
    rcv_idle = 0;
    write_reg(REG_STD, 16'd1);
    write_reg(REG_BLACK, 16'd16384);
    write_reg(REG_NUM, 16'd147);
    write_reg(REG_DEN, 16'd511);
    write_reg(REG_UGAIN, 16'($urandom_range(0, 65535)));
    write_reg(REG_VGAIN, 16'($urandom_range(0, 65535)));
    hold_go = 1;
    add_lines(140);
    drain();

    $display("Sent %0d pixels and checked %0d samples in %0d cycles", pixels_sent,
             samples_seen, cycles);
    $display("Covered PAL and NTSC, extreme gains, restarts, one-pixel lines, long stall");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/cve_pkg.sv
hdl/cve_cell.sv
hdl/cve_comp.sv
hdl/composite_video_line_encoder_core.sv
hdl/cve_checker.sv
tb/sv/composite_video_line_encoder_core_test.sv
